[hw/rtl/fgc_pkg.sv]
// Shared types, widths and status codes for the glyph cache.
`default_nettype none

package fgc_pkg;

  localparam int DEFAULT_DEPTH = 256;

  localparam int CP_W     = 21;
  localparam int SIZE_W   = 8;
  localparam int KEY_W    = SIZE_W + CP_W;
  localparam int GLYPH_W  = 64;
  localparam int CAP_W    = 9;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd16;

  // Register indexes.
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_GLYPH_SIZE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FILLED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BYPASS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [CP_W-1:0]    code_point;
    logic               load_ok;
    logic [GLYPH_W-1:0] loaded_glyph;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GLYPH_W-1:0]  glyph_word;
    logic [ECOUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity;
    logic [SIZE_W-1:0] glyph_size;
  } cfg_regs_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                clear;
    logic                set_bypass;
    logic                srch_start;
    logic                issue;
    logic                evict;
    logic                insert;
    logic                word_hit;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic bypass;
    logic cap_zero;
    logic load_ok;
    logic hit;
    logic more;
    logic pend;
    logic evict_need;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/fifo_glyph_cache_top.sv]
// A clear or a bypassed item goes from the decide state straight to the result state.
// A lookup searches the stored entries, reading one entry per cycle through the single RAM
// read port; a hit ends the search early.
// A fill evicts the oldest entries as needed, then inserts; a stalled result holds the block.
// Throughput: one item at a time; the next item is accepted from the cycle after the result
// is registered. Reset (synchronous, active low) empties the cache through its pointers.
`default_nettype none

module fifo_glyph_cache_top #(
  parameter int CACHE_DEPTH = fgc_pkg::DEFAULT_DEPTH
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  fgc_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  wire                         out_stall,
  output fgc_pkg::out_item_t          out_item,
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire  [fgc_pkg::PADDR_W-1:0] cfg_paddr,
  input  wire  [fgc_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [fgc_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  fgc_pkg::cfg_regs_t regs;
  fgc_pkg::dp_cmd_t   cmd;
  fgc_pkg::dp_sts_t   sts;

  fgc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  fgc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fgc_dpath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .regs      (regs),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[hw/rtl/fgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                      wdata,
  input  wire                                   re,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fgc_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none

module fgc_regs (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [fgc_pkg::PADDR_W-1:0] paddr,
  input  wire  [fgc_pkg::PDATA_W-1:0] pwdata,
  output logic [fgc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output fgc_pkg::cfg_regs_t          regs
);

  fgc_pkg::cfg_regs_t regs_r;
  fgc_pkg::cfg_regs_t regs_nxt;
  logic               addr_ok;
  logic               wr_en;

  assign pready  = 1'b1;
  assign addr_ok = (paddr[1:0] == 2'b00);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (paddr[2])
        fgc_pkg::REG_CAPACITY:   regs_nxt.capacity   = pwdata[fgc_pkg::CAP_W-1:0];
        fgc_pkg::REG_GLYPH_SIZE: regs_nxt.glyph_size = pwdata[fgc_pkg::SIZE_W-1:0];
        default:                 regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.capacity   <= fgc_pkg::CAP_RESET;
      regs_r.glyph_size <= fgc_pkg::SIZE_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      unique case (paddr[2])
        fgc_pkg::REG_CAPACITY:
          prdata = {{(fgc_pkg::PDATA_W - fgc_pkg::CAP_W){1'b0}}, regs_r.capacity};
        fgc_pkg::REG_GLYPH_SIZE:
          prdata = {{(fgc_pkg::PDATA_W - fgc_pkg::SIZE_W){1'b0}}, regs_r.glyph_size};
        default: prdata = '0;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

[hw/rtl/fgc_ctrl.sv]
// Controller state machine: sequences decode, search, eviction and result.
`default_nettype none

module fgc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  fgc_pkg::dp_sts_t    sts,
  output fgc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SEARCH,
    S_EVICT,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.action == fgc_pkg::ACT_CLEAR) begin
          cmd.clear      = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = fgc_pkg::ST_CLEARED;
          state_nxt      = S_RESULT;
        end else if (sts.bypass) begin
          cmd.set_status = 1'b1;
          cmd.status     = fgc_pkg::ST_BYPASS;
          state_nxt      = S_RESULT;
        end else if (sts.cap_zero) begin
          cmd.set_bypass = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = fgc_pkg::ST_BYPASS;
          state_nxt      = S_RESULT;
        end else begin
          cmd.srch_start = 1'b1;
          state_nxt      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // A read is issued every cycle while entries remain; the compare follows in the next cycle.
        if (sts.hit) begin
          cmd.word_hit   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = fgc_pkg::ST_HIT;
          state_nxt      = S_RESULT;
        end else if (sts.more) begin
          cmd.issue = 1'b1;
        end else if (!sts.pend) begin
          if (!sts.load_ok) begin
            cmd.set_status = 1'b1;
            cmd.status     = fgc_pkg::ST_FAILED;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_EVICT;
          end
        end
      end
      S_EVICT: begin
        if (sts.evict_need) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.insert     = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = fgc_pkg::ST_FILLED;
          state_nxt      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fgc_dpath.sv]
// Datapath: FIFO pointers, entry store, key compare and result register.
`default_nettype none

module fgc_dpath #(
  parameter int CACHE_DEPTH = fgc_pkg::DEFAULT_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fgc_pkg::in_item_t   in_item,
  input  fgc_pkg::cfg_regs_t  regs,
  input  fgc_pkg::dp_cmd_t    cmd,
  output fgc_pkg::dp_sts_t    sts,
  output logic                out_valid,
  input  wire                 out_stall,
  output fgc_pkg::out_item_t  out_item
);

  localparam int PW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam int EW = (CW > fgc_pkg::CAP_W) ? CW : fgc_pkg::CAP_W;
  localparam int RW = fgc_pkg::KEY_W + fgc_pkg::GLYPH_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(CACHE_DEPTH - 1);
  localparam logic [EW-1:0] DEPTH_E   = EW'(CACHE_DEPTH);

  fgc_pkg::in_item_t             item_r;
  logic [PW-1:0]                 oldest_r, oldest_nxt;
  logic [PW-1:0]                 newest_r, newest_nxt;
  logic [PW-1:0]                 srch_r, srch_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 issued_r, issued_nxt;
  logic                          pend_r, pend_nxt;
  logic                          bypass_r, bypass_nxt;
  logic [fgc_pkg::GLYPH_W-1:0]   word_r;
  logic [fgc_pkg::STATUS_W-1:0]  status_r;
  logic                          out_valid_r, out_valid_nxt;
  fgc_pkg::out_item_t            out_item_r;

  logic [fgc_pkg::KEY_W-1:0]     key;
  logic [RW-1:0]                 rdata;
  logic [fgc_pkg::KEY_W-1:0]     rd_key;
  logic [fgc_pkg::GLYPH_W-1:0]   rd_glyph;
  logic [EW-1:0]                 cap_raw_e;
  logic [EW-1:0]                 cap_e;
  logic [EW-1:0]                 count_e;
  logic [EW+fgc_pkg::ECOUNT_W-1:0] count_wide;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign key      = {regs.glyph_size, item_r.code_point};
  assign rd_key   = rdata[RW-1:fgc_pkg::GLYPH_W];
  assign rd_glyph = rdata[fgc_pkg::GLYPH_W-1:0];

  // Capacity saturates at the store depth.
  assign cap_raw_e = EW'(regs.capacity);
  assign cap_e     = (cap_raw_e > DEPTH_E) ? DEPTH_E : cap_raw_e;
  assign count_e   = EW'(count_r);
  assign count_wide = {{fgc_pkg::ECOUNT_W{1'b0}}, count_e};

  fgc_ram #(
    .WIDTH (RW),
    .DEPTH (CACHE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (newest_r),
    .wdata ({key, item_r.loaded_glyph}),
    .re    (cmd.issue),
    .raddr (srch_r),
    .rdata (rdata)
  );

  always_comb begin
    sts.action     = item_r.action;
    sts.bypass     = bypass_r;
    sts.cap_zero   = (regs.capacity == '0);
    sts.load_ok    = item_r.load_ok;
    sts.hit        = pend_r && (rd_key == key);
    sts.more       = (issued_r != count_r);
    sts.pend       = pend_r;
    sts.evict_need = (count_e >= cap_e) && (count_r != '0);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    oldest_nxt = oldest_r;
    newest_nxt = newest_r;
    srch_nxt   = srch_r;
    count_nxt  = count_r;
    issued_nxt = issued_r;
    pend_nxt   = cmd.issue;
    bypass_nxt = bypass_r | cmd.set_bypass;
    if (cmd.clear) begin
      oldest_nxt = '0;
      newest_nxt = '0;
      count_nxt  = '0;
    end
    if (cmd.srch_start) begin
      srch_nxt   = oldest_r;
      issued_nxt = '0;
    end
    if (cmd.issue) begin
      srch_nxt   = next_slot(srch_r);
      issued_nxt = issued_r + 1'b1;
    end
    if (cmd.evict) begin
      oldest_nxt = next_slot(oldest_r);
      count_nxt  = count_r - 1'b1;
    end
    if (cmd.insert) begin
      newest_nxt = next_slot(newest_r);
      count_nxt  = count_r + 1'b1;
    end
    out_valid_nxt = cmd.emit | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      newest_r    <= '0;
      srch_r      <= '0;
      count_r     <= '0;
      issued_r    <= '0;
      pend_r      <= 1'b0;
      bypass_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      srch_r      <= srch_nxt;
      count_r     <= count_nxt;
      issued_r    <= issued_nxt;
      pend_r      <= pend_nxt;
      bypass_r    <= bypass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      word_r <= '0;
    end else if (cmd.word_hit) begin
      word_r <= rd_glyph;
    end else if (cmd.insert) begin
      word_r <= item_r.loaded_glyph;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.emit) begin
      out_item_r.status      <= status_r;
      out_item_r.glyph_word  <= word_r;
      out_item_r.entry_count <= count_wide[fgc_pkg::ECOUNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
